FILE: sv/id3v2_frame_parser_assert.svh
// ------------------------------------------------------------------------
// id3v2 frame parser assertion macros
// shared property wrappers, clocked on clk with rst_n as disable
// ------------------------------------------------------------------------
`ifndef ID3V2_FRAME_PARSER_ASSERT_SVH
`define ID3V2_FRAME_PARSER_ASSERT_SVH

// same-cycle implication
`define ID3FP_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ID3FP_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/id3fp_pkg.sv
// ------------------------------------------------------------------------
// id3fp_pkg
// shared types and codes for the id3v2 frame parser
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

package id3fp_pkg;

    // result kinds
    localparam logic [1:0] KIND_NAME   = 2'd0;
    localparam logic [1:0] KIND_UNIT   = 2'd1;
    localparam logic [1:0] KIND_RAW    = 2'd2;
    localparam logic [1:0] KIND_STATUS = 2'd3;

    // frame status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_ENC = 2'd1;
    localparam logic [1:0] ST_BAD_BOM = 2'd2;

    // byte values
    localparam logic [7:0] CHAR_T   = 8'h54;
    localparam logic [7:0] ENC_LAT1 = 8'h00;
    localparam logic [7:0] ENC_U16  = 8'h01;
    localparam logic [7:0] BOM_FE   = 8'hFE;
    localparam logic [7:0] BOM_FF   = 8'hFF;

    localparam int HDR_LEN = 10;
    localparam int MAX_RES = 3;
    localparam int QDEPTH  = 4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] value;
        logic [1:0]  status;
        logic        last;
    } item_t;

    function automatic item_t make_item(logic [1:0] kind, logic [15:0] value,
                                        logic [1:0] status, logic last);
        item_t it;
        it.kind   = kind;
        it.value  = value;
        it.status = status;
        it.last   = last;
        return it;
    endfunction

endpackage

FILE: sv/id3v2_frame_parser.sv
// results of an accepted word are written to a 4-entry result queue in the same cycle
// and are presented on the output from the queue registers, in the order written
// throughput: one word per cycle while each word yields at most one result and out_stall is low; a frame
// end can yield up to three, and input then stalls while the single output drains them
// rst_n (async, active low) clears parser state and empties the queue
`timescale 1ns / 1ps

// ------------------------------------------------------------------------
// id3v2_frame_parser
// header reader, text decoder (latin-1 / utf-16) and raw pass-through
// ------------------------------------------------------------------------
module id3v2_frame_parser #(
    parameter int SIZE_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        frame_start,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  out_kind,
    output logic [15:0] out_value,
    output logic [1:0]  frame_status,
    output logic        last_of_frame
);
    import id3fp_pkg::*;

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_HEADER = 3'd1;
    localparam logic [2:0] PH_ENC    = 3'd2;
    localparam logic [2:0] PH_BOM1   = 3'd3;
    localparam logic [2:0] PH_BOM2   = 3'd4;
    localparam logic [2:0] PH_TEXT   = 3'd5;
    localparam logic [2:0] PH_RAW    = 3'd6;
    localparam logic [2:0] PH_SKIP   = 3'd7;

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_W = $clog2(QDEPTH + 1);

    logic [2:0]           phase_reg, phase_next;
    logic [3:0]           hidx_reg, hidx_next;
    logic [SIZE_BITS-1:0] left_reg, left_next;
    logic                 is_text_reg, is_text_next;
    logic                 enc_reg, enc_next;
    logic                 big_endian_reg, big_endian_next;
    logic [7:0]           fpb_reg, fpb_next;
    logic                 in_pair_reg, in_pair_next;
    logic [15:0]          held_reg, held_next;
    logic                 held_valid_reg, held_valid_next;
    logic [1:0]           err_reg, err_next;

    item_t                res [MAX_RES];
    logic [1:0]           res_n;
    logic                 body_end;
    logic [15:0]          unit;

    item_t                queue_reg [QDEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]     count_reg;
    logic                 accept, pop;

    assign in_stall = (count_reg > CNT_W'(QDEPTH - MAX_RES));
    assign accept   = in_valid && !in_stall;
    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && !out_stall;

    assign out_kind      = queue_reg[rd_ptr_reg].kind;
    assign out_value     = queue_reg[rd_ptr_reg].value;
    assign frame_status  = queue_reg[rd_ptr_reg].status;
    assign last_of_frame = queue_reg[rd_ptr_reg].last;

    always_comb
    begin
        phase_next      = phase_reg;
        hidx_next       = hidx_reg;
        left_next       = left_reg;
        is_text_next    = is_text_reg;
        enc_next        = enc_reg;
        big_endian_next = big_endian_reg;
        fpb_next        = fpb_reg;
        in_pair_next    = in_pair_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        err_next        = err_reg;
        res_n           = 2'd0;
        body_end        = 1'b0;
        unit            = 16'd0;
        for (int k = 0; k < MAX_RES; k++)
        begin
            res[k] = '0;
        end

        if (accept)
        begin
            if (frame_start)
            begin
                phase_next      = PH_HEADER;
                hidx_next       = 4'd0;
                left_next       = '0;
                is_text_next    = 1'b0;
                enc_next        = 1'b0;
                big_endian_next = 1'b0;
                fpb_next        = 8'd0;
                in_pair_next    = 1'b0;
                held_next       = 16'd0;
                held_valid_next = 1'b0;
                err_next        = ST_OK;
            end

            if (phase_next == PH_HEADER)
            begin
                if (hidx_next < 4'd4)
                begin
                    if (hidx_next == 4'd0)
                    begin
                        is_text_next = (data_byte == CHAR_T);
                    end
                    res[res_n] = make_item(KIND_NAME, {8'd0, data_byte}, ST_OK, 1'b0);
                    res_n = res_n + 2'd1;
                end
                else if (hidx_next < 4'd8)
                begin
                    // size accumulates in the byte counter, upper bytes fall off when SIZE_BITS is below 32
                    left_next = (left_next << 8) | SIZE_BITS'(data_byte);
                end
                if (hidx_next >= 4'(HDR_LEN - 1))
                begin
                    hidx_next  = 4'd0;
                    phase_next = is_text_next ? PH_ENC : PH_RAW;
                    body_end   = (left_next == '0);
                end
                else
                begin
                    hidx_next = hidx_next + 4'd1;
                end
            end
            else if (phase_next != PH_IDLE)
            begin
                left_next = left_next - SIZE_BITS'(1);
                body_end  = (left_next == '0);
                case (phase_next)
                    PH_ENC:
                    begin
                        if (data_byte == ENC_LAT1)
                        begin
                            enc_next   = 1'b0;
                            phase_next = PH_TEXT;
                        end
                        else if (data_byte == ENC_U16)
                        begin
                            enc_next   = 1'b1;
                            phase_next = PH_BOM1;
                            if (body_end)
                            begin
                                err_next = ST_BAD_BOM;
                            end
                        end
                        else
                        begin
                            err_next   = ST_BAD_ENC;
                            phase_next = PH_SKIP;
                        end
                    end
                    PH_BOM1:
                    begin
                        fpb_next   = data_byte;
                        phase_next = PH_BOM2;
                        if (body_end)
                        begin
                            err_next = ST_BAD_BOM;
                        end
                    end
                    PH_BOM2:
                    begin
                        if ((fpb_next == BOM_FE && data_byte == BOM_FF) ||
                            (fpb_next == BOM_FF && data_byte == BOM_FE))
                        begin
                            big_endian_next = (fpb_next == BOM_FE);
                            phase_next      = PH_TEXT;
                        end
                        else
                        begin
                            err_next   = ST_BAD_BOM;
                            phase_next = PH_SKIP;
                        end
                        fpb_next = 8'd0;
                    end
                    PH_TEXT:
                    begin
                        if (!enc_next || in_pair_next)
                        begin
                            if (!enc_next)
                            begin
                                unit = {8'd0, data_byte};
                            end
                            else if (big_endian_next)
                            begin
                                unit = {fpb_next, data_byte};
                            end
                            else
                            begin
                                unit = {data_byte, fpb_next};
                            end
                            in_pair_next = 1'b0;
                            // one-unit hold so a trailing null can be dropped
                            if (held_valid_next)
                            begin
                                res[res_n] = make_item(KIND_UNIT, held_next, ST_OK, 1'b0);
                                res_n = res_n + 2'd1;
                            end
                            held_next       = unit;
                            held_valid_next = 1'b1;
                        end
                        else if (data_byte != BOM_FE && data_byte != BOM_FF)
                        begin
                            fpb_next     = data_byte;
                            in_pair_next = 1'b1;
                        end
                    end
                    PH_RAW:
                    begin
                        res[res_n] = make_item(KIND_RAW, {8'd0, data_byte}, ST_OK, 1'b0);
                        res_n = res_n + 2'd1;
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (body_end)
            begin
                if (phase_next == PH_TEXT && held_valid_next && held_next != 16'd0)
                begin
                    res[res_n] = make_item(KIND_UNIT, held_next, ST_OK, 1'b0);
                    res_n = res_n + 2'd1;
                end
                held_valid_next = 1'b0;
                in_pair_next    = 1'b0;
                res[res_n] = make_item(KIND_STATUS, {14'd0, err_next}, err_next, 1'b1);
                res_n = res_n + 2'd1;
                phase_next = PH_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            hidx_reg       <= 4'd0;
            left_reg       <= '0;
            is_text_reg    <= 1'b0;
            enc_reg        <= 1'b0;
            big_endian_reg <= 1'b0;
            fpb_reg        <= 8'd0;
            in_pair_reg    <= 1'b0;
            held_reg       <= 16'd0;
            held_valid_reg <= 1'b0;
            err_reg        <= ST_OK;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            hidx_reg       <= hidx_next;
            left_reg       <= left_next;
            is_text_reg    <= is_text_next;
            enc_reg        <= enc_next;
            big_endian_reg <= big_endian_next;
            fpb_reg        <= fpb_next;
            in_pair_reg    <= in_pair_next;
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
            err_reg        <= err_next;
            wr_ptr_reg     <= wr_ptr_reg + PTR_W'(res_n);
            rd_ptr_reg     <= rd_ptr_reg + PTR_W'(pop);
            count_reg      <= count_reg + CNT_W'(res_n) - CNT_W'(pop);
        end
    end

    // result queue payload
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_RES; k++)
        begin
            if (2'(k) < res_n)
            begin
                queue_reg[wr_ptr_reg + PTR_W'(k)] <= res[k];
            end
        end
    end

endmodule

FILE: sv/id3fp_checker.sv
// ------------------------------------------------------------------------
// id3fp_checker
// port-level checks on the result channel of the frame parser
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "id3v2_frame_parser_assert.svh"

module id3fp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  out_kind,
    input logic [15:0] out_value,
    input logic [1:0]  frame_status,
    input logic        last_of_frame
);
    import id3fp_pkg::*;

    `ID3FP_IMPLIES(a_last_is_status, out_valid,
        last_of_frame == (out_kind == KIND_STATUS),
        "last flag does not match status word")
    `ID3FP_IMPLIES(a_status_only_on_end, out_valid && out_kind != KIND_STATUS,
        frame_status == ST_OK,
        "nonzero status on a data word")
    `ID3FP_IMPLIES(a_status_value, out_valid && out_kind == KIND_STATUS,
        out_value == {14'd0, frame_status} && frame_status != 2'd3,
        "status word value mismatch")
    `ID3FP_NEXT(a_hold_stalled, out_valid && out_stall,
        out_valid && $stable(out_value) && $stable(out_kind),
        "stalled result word changed")

endmodule

bind id3v2_frame_parser id3fp_checker u_id3fp_checker (.*);
